// ===== hdl/m3i_pkg.sv =====
// Shared constants, cofactor index table and flag struct for the 3x3 matrix inverse.
// No dependencies; all other files but m3i_if use this package by scoped names.
package m3i_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NELEM          = 9;
  localparam int THR_WIDTH      = 31;
  localparam int ADDR_WIDTH     = 3;
  localparam int DATA_WIDTH     = 32;

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

  // register index, taken from paddr[ADDR_WIDTH-1]
  localparam logic REG_THRESHOLD = 1'b0;

  // minor i = e[a]*e[b] - e[c]*e[d], elements in column-major order
  localparam logic [3:0] MINOR_IDX [NELEM][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  typedef struct packed {
    logic             singular;
    logic [NELEM-1:0] neg;
    logic [NELEM-1:0] ovf;
  } flags_t;

endpackage

// ===== hdl/m3i_if.sv =====
// Valid/ready channel interfaces for matrix items and inverse result items.
// Depends on nothing; widths come from the W parameter.
interface m3i_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_c0_r0;
  logic signed [W-1:0] in_c0_r1;
  logic signed [W-1:0] in_c0_r2;
  logic signed [W-1:0] in_c1_r0;
  logic signed [W-1:0] in_c1_r1;
  logic signed [W-1:0] in_c1_r2;
  logic signed [W-1:0] in_c2_r0;
  logic signed [W-1:0] in_c2_r1;
  logic signed [W-1:0] in_c2_r2;

  modport source (output valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                  in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, input ready);
  modport sink (input valid, in_c0_r0, in_c0_r1, in_c0_r2, in_c1_r0, in_c1_r1,
                in_c1_r2, in_c2_r0, in_c2_r1, in_c2_r2, output ready);
endinterface

interface m3i_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_c0_r0;
  logic signed [W-1:0] out_c0_r1;
  logic signed [W-1:0] out_c0_r2;
  logic signed [W-1:0] out_c1_r0;
  logic signed [W-1:0] out_c1_r1;
  logic signed [W-1:0] out_c1_r2;
  logic signed [W-1:0] out_c2_r0;
  logic signed [W-1:0] out_c2_r1;
  logic signed [W-1:0] out_c2_r2;
  logic                singular;
  logic signed [W-1:0] determinant;

  modport source (output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                  out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, determinant,
                  input ready);
  modport sink (input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, determinant,
                output ready);
endinterface

// ===== hdl/m3i_cofactor.sv =====
// Five-stage pipeline: 2x2 minors and the exact full-width determinant.
// Depends on m3i_pkg (index table, element count).
module m3i_cofactor #(
  parameter int W = m3i_pkg::ELEM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] elem [m3i_pkg::NELEM],
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [2*W:0] minor [m3i_pkg::NELEM],
  output logic signed [3*W+2:0] det
);
  localparam int N    = m3i_pkg::NELEM;
  localparam int PW   = 2 * W;
  localparam int MW   = 2 * W + 1;
  localparam int TRMW = 3 * W + 1;
  localparam int DETW = 3 * W + 3;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic signed [PW-1:0]   pa1 [N];
  logic signed [PW-1:0]   pb1 [N];
  logic signed [W-1:0]    ecol1 [3];
  logic signed [W-1:0]    ecol2 [3];
  logic signed [MW-1:0]   mn2 [N];
  logic signed [MW-1:0]   mn3 [N];
  logic signed [MW-1:0]   mn4 [N];
  logic signed [MW-1:0]   mn5 [N];
  logic signed [2*W:0]    pl3 [3];
  logic signed [2*W:0]    ph3 [3];
  logic signed [TRMW-1:0] tm4 [3];
  logic signed [DETW-1:0] det5;

  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v5;
  assign minor     = mn5;
  assign det       = det5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // products of element pairs
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < N; i++) begin
        pa1[i] <= elem[m3i_pkg::MINOR_IDX[i][0]] * elem[m3i_pkg::MINOR_IDX[i][1]];
        pb1[i] <= elem[m3i_pkg::MINOR_IDX[i][2]] * elem[m3i_pkg::MINOR_IDX[i][3]];
      end
      for (int j = 0; j < 3; j++) ecol1[j] <= elem[3*j];
    end
  end

  // minors
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < N; i++) mn2[i] <= MW'(pa1[i]) - MW'(pb1[i]);
      ecol2 <= ecol1;
    end
  end

  // first-row element times minor, split into low and high partial products
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int j = 0; j < 3; j++) begin
        pl3[j] <= ecol2[j] * $signed({1'b0, mn2[j][W-1:0]});
        ph3[j] <= ecol2[j] * $signed(mn2[j][MW-1:W]);
      end
      mn3 <= mn2;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int j = 0; j < 3; j++) tm4[j] <= (TRMW'(ph3[j]) <<< W) + TRMW'(pl3[j]);
      mn4 <= mn3;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      det5 <= DETW'(tm4[0]) + DETW'(tm4[1]) + DETW'(tm4[2]);
      mn5  <= mn4;
    end
  end

endmodule

// ===== hdl/m3i_prep.sv =====
// Two-stage pipeline: magnitudes, signs, saturated determinant, singular and overflow tests.
// Depends on m3i_pkg (flags_t, element count, threshold width).
module m3i_prep #(
  parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [m3i_pkg::THR_WIDTH-1:0]     threshold,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [2*W:0]               minor [m3i_pkg::NELEM],
  input  logic signed [3*W+2:0]             det,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2*W+2*F:0]                  num [m3i_pkg::NELEM],
  output logic [3*W+2:0]                    dabs,
  output m3i_pkg::flags_t                   flags,
  output logic signed [W-1:0]               det_out
);
  localparam int N    = m3i_pkg::NELEM;
  localparam int MW   = 2 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int NUMW = MW + 2 * F;
  localparam int TW   = (W - 1 < m3i_pkg::THR_WIDTH) ? W - 1 : m3i_pkg::THR_WIDTH;
  localparam int CMPW = (DETW > TW + 2 * F) ? DETW : TW + 2 * F;
  localparam int OVW  = (NUMW > DETW + W + 1) ? NUMW : DETW + W + 1;
  localparam logic signed [W-1:0] MAXPOS = W'({(W-1){1'b1}});
  localparam logic signed [W-1:0] MINNEG = ~MAXPOS;

  logic v6, v7, en6, en7;

  logic [MW-1:0]          mmag [N];
  logic signed [DETW-1:0] dsh;
  logic [DETW-W:0]        dtop;
  logic signed [W-1:0]    dsat;

  logic [NUMW-1:0]     num6 [N];
  logic [DETW-1:0]     dabs6;
  logic [N-1:0]        neg6;
  logic                dz6;
  logic signed [W-1:0] dout6;

  logic [NUMW-1:0]     num7 [N];
  logic [DETW-1:0]     dabs7;
  m3i_pkg::flags_t     fl7;
  logic signed [W-1:0] dout7;

  assign en7 = !v7 || out_ready;
  assign en6 = !v6 || en7;
  assign in_ready  = en6;
  assign out_valid = v7;
  assign num       = num7;
  assign dabs      = dabs7;
  assign flags     = fl7;
  assign det_out   = dout7;

  always_comb begin
    for (int i = 0; i < N; i++) mmag[i] = minor[i][MW-1] ? MW'(-minor[i]) : MW'(minor[i]);
    dsh  = det >>> (2 * F);
    dtop = dsh[DETW-1:W-1];
    if ((&dtop) || !(|dtop)) dsat = dsh[W-1:0];
    else if (dsh[DETW-1])    dsat = MINNEG;
    else                     dsat = MAXPOS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en6) v6 <= in_valid;
      if (en7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int i = 0; i < N; i++) begin
        num6[i] <= {mmag[i], {(2*F){1'b0}}};
        neg6[i] <= minor[i][MW-1] ^ det[DETW-1];
      end
      dabs6 <= det[DETW-1] ? DETW'(-det) : DETW'(det);
      dz6   <= (det == '0);
      dout6 <= dsat;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      for (int i = 0; i < N; i++) begin
        fl7.ovf[i] <= (OVW'(num6[i]) >= (OVW'(dabs6) << (W + 1)));
      end
      fl7.neg      <= neg6;
      fl7.singular <= dz6 || (CMPW'(dabs6) < (CMPW'(threshold[TW-1:0]) << (2 * F)));
      num7  <= num6;
      dabs7 <= dabs6;
      dout7 <= dout6;
    end
  end

endmodule

// ===== hdl/m3i_divider.sv =====
// Restoring divider pipeline, one quotient bit per stage, nine lanes sharing one divisor.
// Depends on m3i_pkg (flags_t, element count).
module m3i_divider #(
  parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*W+2*F:0]      num [m3i_pkg::NELEM],
  input  logic [3*W+2:0]        dabs,
  input  m3i_pkg::flags_t       flags,
  input  logic signed [W-1:0]   det_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [W:0]            quo [m3i_pkg::NELEM],
  output m3i_pkg::flags_t       flags_out,
  output logic signed [W-1:0]   det_out
);
  localparam int N    = m3i_pkg::NELEM;
  localparam int NUMW = 2 * W + 2 * F + 1;
  localparam int DETW = 3 * W + 3;
  localparam int HW   = W + 1;
  localparam int S    = W + 1;
  localparam int CW   = (NUMW > DETW + W + 1) ? NUMW : DETW + W + 1;

  logic [S+1:1]        en;
  logic                v   [1:S];
  logic [NUMW-1:0]     rem [1:S][N];
  logic [HW-1:0]       q   [1:S][N];
  logic [DETW-1:0]     dv  [1:S];
  m3i_pkg::flags_t     fl  [1:S];
  logic signed [W-1:0] dq  [1:S];

  assign en[S+1]   = out_ready;
  assign in_ready  = en[1];
  assign out_valid = v[S];
  assign quo       = q[S];
  assign flags_out = fl[S];
  assign det_out   = dq[S];

  for (genvar s = 1; s <= S; s++) begin : g_stage
    localparam int K = W + 1 - s;
    logic                pv;
    logic [NUMW-1:0]     prem [N];
    logic [HW-1:0]       pq   [N];
    logic [DETW-1:0]     pdv;
    m3i_pkg::flags_t     pfl;
    logic signed [W-1:0] pdq;
    logic [CW-1:0]       shd;
    logic [N-1:0]        ge;

    if (s == 1) begin : g_first
      assign pv   = in_valid;
      assign prem = num;
      assign pdv  = dabs;
      assign pfl  = flags;
      assign pdq  = det_in;
      for (genvar i = 0; i < N; i++) begin : g_q0
        assign pq[i] = '0;
      end
    end else begin : g_next
      assign pv   = v[s-1];
      assign prem = rem[s-1];
      assign pq   = q[s-1];
      assign pdv  = dv[s-1];
      assign pfl  = fl[s-1];
      assign pdq  = dq[s-1];
    end

    assign en[s] = !v[s] || en[s+1];
    assign shd   = CW'(pdv) << K;

    always_comb begin
      for (int i = 0; i < N; i++) ge[i] = (CW'(prem[i]) >= shd);
    end

    always_ff @(posedge clk) begin
      if (rst) v[s] <= 1'b0;
      else if (en[s]) v[s] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        for (int i = 0; i < N; i++) begin
          rem[s][i] <= ge[i] ? NUMW'(CW'(prem[i]) - shd) : prem[i];
          q[s][i]   <= pq[i] | (HW'(ge[i]) << K);
        end
        dv[s] <= pdv;
        fl[s] <= pfl;
        dq[s] <= pdq;
      end
    end
  end

endmodule

// ===== hdl/m3i_output.sv =====
// Output register: sign, saturation and identity selection for singular matrices.
// Depends on m3i_pkg (flags_t, element count).
module m3i_output #(
  parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [W:0]          quo [m3i_pkg::NELEM],
  input  m3i_pkg::flags_t     flags,
  input  logic signed [W-1:0] det_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] res [m3i_pkg::NELEM],
  output logic                singular,
  output logic signed [W-1:0] determinant
);
  localparam int N = m3i_pkg::NELEM;
  localparam logic signed [W-1:0] MAXPOS = W'({(W-1){1'b1}});
  localparam logic signed [W-1:0] MINNEG = ~MAXPOS;
  localparam logic signed [W-1:0] ONE = (F < W - 1) ? (W'(1) << F) : MAXPOS;

  logic signed [W-1:0] val [N];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (flags.singular) begin
        val[i] = (i % 4 == 0) ? ONE : '0;
      end else if (flags.neg[i]) begin
        if (flags.ovf[i] || quo[i][W] || (quo[i][W-1] && (|quo[i][W-2:0]))) val[i] = MINNEG;
        else val[i] = -$signed(quo[i][W-1:0]);
      end else begin
        if (flags.ovf[i] || quo[i][W] || quo[i][W-1]) val[i] = MAXPOS;
        else val[i] = $signed(quo[i][W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res         <= val;
      singular    <= flags.singular;
      determinant <= det_in;
    end
  end

endmodule

// ===== hdl/matrix3_inverse_top.sv =====
// Inverse of a 3x3 signed fixed-point matrix (Q16.16 by default) by adjugate over
// determinant, with a determinant threshold register on an APB-style port (byte address 0,
// reset value 1). A new matrix item is accepted every cycle unless a held output
// has backed up the pipeline. Each item passes through the minor and determinant
// stages, the magnitude and singular-test stages, the ELEM_WIDTH + 1 stage divider
// pipeline (one per quotient bit) and the output register. Stages advance
// independently, so empty stages fill while the output is held. Items whose determinant
// magnitude is below the threshold, or is zero, return the identity with singular set.
// Depends on m3i_pkg, m3i_if and the m3i_* pipeline modules.
module matrix3_inverse_top #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [m3i_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [m3i_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [m3i_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready,
  m3i_in_if.sink                            din,
  m3i_out_if.source                         dout
);
  localparam int W    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int N    = m3i_pkg::NELEM;

  logic [m3i_pkg::THR_WIDTH-1:0] threshold;

  logic signed [W-1:0]     elem [N];
  logic                    cf_valid, cf_ready;
  logic signed [2*W:0]     minor [N];
  logic signed [3*W+2:0]   det;
  logic                    pp_valid, pp_ready;
  logic [2*W+2*F:0]        num [N];
  logic [3*W+2:0]          dabs;
  m3i_pkg::flags_t         pp_flags;
  logic signed [W-1:0]     pp_det;
  logic                    dv_valid, dv_ready;
  logic [W:0]              quo [N];
  m3i_pkg::flags_t         dv_flags;
  logic signed [W-1:0]     dv_det;
  logic signed [W-1:0]     res [N];

  assign pready = 1'b1;
  assign prdata = (paddr[m3i_pkg::ADDR_WIDTH-1] == m3i_pkg::REG_THRESHOLD)
                  ? m3i_pkg::DATA_WIDTH'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= m3i_pkg::THR_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[m3i_pkg::ADDR_WIDTH-1] == m3i_pkg::REG_THRESHOLD) begin
      threshold <= pwdata[m3i_pkg::THR_WIDTH-1:0];
    end
  end

  assign elem[0] = din.in_c0_r0;
  assign elem[1] = din.in_c0_r1;
  assign elem[2] = din.in_c0_r2;
  assign elem[3] = din.in_c1_r0;
  assign elem[4] = din.in_c1_r1;
  assign elem[5] = din.in_c1_r2;
  assign elem[6] = din.in_c2_r0;
  assign elem[7] = din.in_c2_r1;
  assign elem[8] = din.in_c2_r2;

  m3i_cofactor #(.W(W)) u_cofactor (
    .clk(clk), .rst(rst),
    .in_valid(din.valid), .in_ready(din.ready), .elem(elem),
    .out_valid(cf_valid), .out_ready(cf_ready), .minor(minor), .det(det)
  );

  m3i_prep #(.W(W), .F(F)) u_prep (
    .clk(clk), .rst(rst), .threshold(threshold),
    .in_valid(cf_valid), .in_ready(cf_ready), .minor(minor), .det(det),
    .out_valid(pp_valid), .out_ready(pp_ready),
    .num(num), .dabs(dabs), .flags(pp_flags), .det_out(pp_det)
  );

  m3i_divider #(.W(W), .F(F)) u_divider (
    .clk(clk), .rst(rst),
    .in_valid(pp_valid), .in_ready(pp_ready),
    .num(num), .dabs(dabs), .flags(pp_flags), .det_in(pp_det),
    .out_valid(dv_valid), .out_ready(dv_ready),
    .quo(quo), .flags_out(dv_flags), .det_out(dv_det)
  );

  m3i_output #(.W(W), .F(F)) u_output (
    .clk(clk), .rst(rst),
    .in_valid(dv_valid), .in_ready(dv_ready),
    .quo(quo), .flags(dv_flags), .det_in(dv_det),
    .out_valid(dout.valid), .out_ready(dout.ready),
    .res(res), .singular(dout.singular), .determinant(dout.determinant)
  );

  assign dout.out_c0_r0 = res[0];
  assign dout.out_c0_r1 = res[1];
  assign dout.out_c0_r2 = res[2];
  assign dout.out_c1_r0 = res[3];
  assign dout.out_c1_r1 = res[4];
  assign dout.out_c1_r2 = res[5];
  assign dout.out_c2_r0 = res[6];
  assign dout.out_c2_r1 = res[7];
  assign dout.out_c2_r2 = res[8];

endmodule

// ===== hdl/m3i_checker.sv =====
// Port-level assertions for matrix3_inverse_top, bound to the top level.
// Depends on m3i_pkg and matrix3_inverse_top.
module m3i_checker #(
  parameter int W = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [m3i_pkg::ADDR_WIDTH-1:0] paddr,
  input logic [m3i_pkg::DATA_WIDTH-1:0] pwdata,
  input logic [m3i_pkg::DATA_WIDTH-1:0] prdata,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [W-1:0]            o00, o01, o02, o10, o11, o12, o20, o21, o22,
  input logic                           singular,
  input logic signed [W-1:0]            determinant
);
  localparam logic signed [W-1:0] MAXPOS = W'({(W-1){1'b1}});
  localparam logic signed [W-1:0] ONE = (F < W - 1) ? (W'(1) << F) : MAXPOS;
  localparam int TH = m3i_pkg::THR_WIDTH;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |->
      o00 == ONE && o11 == ONE && o22 == ONE && o01 == '0 && o02 == '0 &&
      o10 == '0 && o12 == '0 && o20 == '0 && o21 == '0)
    else $error("singular item without identity matrix");

  a_threshold_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[m3i_pkg::ADDR_WIDTH-1] == m3i_pkg::REG_THRESHOLD |=>
      paddr[m3i_pkg::ADDR_WIDTH-1] != m3i_pkg::REG_THRESHOLD ||
      prdata[TH-1:0] == $past(pwdata[TH-1:0]))
    else $error("threshold readback differs from written value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(determinant) && $stable(o00))
    else $error("stalled result item changed");

endmodule

bind matrix3_inverse_top m3i_checker #(.W(ELEM_WIDTH), .F(FRAC_BITS)) u_m3i_checker (
  .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
  .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
  .out_valid(dout.valid), .out_ready(dout.ready),
  .o00(dout.out_c0_r0), .o01(dout.out_c0_r1), .o02(dout.out_c0_r2),
  .o10(dout.out_c1_r0), .o11(dout.out_c1_r1), .o12(dout.out_c1_r2),
  .o20(dout.out_c2_r0), .o21(dout.out_c2_r1), .o22(dout.out_c2_r2),
  .singular(dout.singular), .determinant(dout.determinant)
);

// ===== sim/m3i_inverse_checker.sv =====
// Checker for the 3x3 matrix inverse: watches both channels and the register port,
// predicts each inverse item from the matrix item and compares. Depends on m3i_pkg, m3i_if.
module m3i_inverse_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [m3i_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [m3i_pkg::DATA_WIDTH-1:0] pwdata,
  m3i_in_if.sink       din_mon,
  m3i_out_if.sink      dout_mon,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic [31:0] elem [9];
    logic        singular;
    logic [31:0] det;
  } inverse_t;

  inverse_t inverse_q [$];
  logic [m3i_pkg::THR_WIDTH-1:0] threshold;

  function automatic logic [31:0] sat32(logic signed [255:0] v);
    if (v > 256'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -256'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic inverse_t invert(logic signed [31:0] m [9],
                                      logic [m3i_pkg::THR_WIDTH-1:0] thr);
    inverse_t r;
    logic signed [255:0] e [9];
    logic signed [255:0] mn [9];
    logic signed [255:0] d, q;
    logic [255:0] ad, an;
    for (int i = 0; i < 9; i++) e[i] = m[i];
    for (int i = 0; i < 9; i++)
      mn[i] = e[m3i_pkg::MINOR_IDX[i][0]] * e[m3i_pkg::MINOR_IDX[i][1]] -
              e[m3i_pkg::MINOR_IDX[i][2]] * e[m3i_pkg::MINOR_IDX[i][3]];
    d = e[0] * mn[0] + e[3] * mn[1] + e[6] * mn[2];
    r.det = sat32(d >>> 32);
    ad = d < 0 ? -d : d;
    r.singular = (d == 0) || (ad < ({225'd0, thr} << 32));
    for (int i = 0; i < 9; i++) begin
      if (r.singular) begin
        r.elem[i] = (i % 4 == 0) ? 32'h00010000 : 32'h0;
      end else begin
        an = mn[i] < 0 ? -mn[i] : mn[i];
        q = (an << 32) / ad;
        if ((mn[i] < 0) != (d < 0)) q = -q;
        r.elem[i] = sat32(q);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  assign pending = inverse_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic signed [31:0] m [9];
    logic [31:0] got [9];
    inverse_t w;
    if (rst) begin
      threshold <= m3i_pkg::THR_RESET;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[m3i_pkg::ADDR_WIDTH-1] == m3i_pkg::REG_THRESHOLD)
        threshold <= pwdata[m3i_pkg::THR_WIDTH-1:0];
      if (din_mon.valid && din_mon.ready) begin
        m = '{din_mon.in_c0_r0, din_mon.in_c0_r1, din_mon.in_c0_r2, din_mon.in_c1_r0,
              din_mon.in_c1_r1, din_mon.in_c1_r2, din_mon.in_c2_r0, din_mon.in_c2_r1,
              din_mon.in_c2_r2};
        inverse_q.push_back(invert(m, threshold));
      end
      if (dout_mon.valid && dout_mon.ready) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          w = inverse_q.pop_front();
          got = '{dout_mon.out_c0_r0, dout_mon.out_c0_r1, dout_mon.out_c0_r2,
                  dout_mon.out_c1_r0, dout_mon.out_c1_r1, dout_mon.out_c1_r2,
                  dout_mon.out_c2_r0, dout_mon.out_c2_r1, dout_mon.out_c2_r2};
          for (int i = 0; i < 9; i++)
            if (got[i] !== w.elem[i]) report_mismatch($sformatf("elem %0d", i), got[i], w.elem[i]);
          if (dout_mon.singular !== w.singular)
            report_mismatch("singular", dout_mon.singular, w.singular);
          if (dout_mon.determinant !== w.det)
            report_mismatch("determinant", dout_mon.determinant, w.det);
        end
      end
    end
  end
endmodule

// ===== sim/matrix3_inverse_top_tb.sv =====
// Top of the 3x3 matrix inverse bench: clock, reset, register writes, matrix stimulus
// with idling phases, and the verdict. Depends on m3i_pkg, m3i_if, m3i_inverse_checker.
module matrix3_inverse_top_tb;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [m3i_pkg::ADDR_WIDTH-1:0] paddr;
  logic [m3i_pkg::DATA_WIDTH-1:0] pwdata, prdata;
  int fail_count, pending;
  int send_idle, sink_stall, hold_cycles;

  m3i_in_if  din ();
  m3i_out_if dout ();

  matrix3_inverse_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .din(din), .dout(dout)
  );

  m3i_inverse_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .din_mon(din), .dout_mon(dout),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall, or a long hold-off while hold_cycles runs down
  initial begin
    dout.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        dout.ready <= 0;
      end else begin
        dout.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h80000000 | $urandom_range(3);
      2: return 32'h7FFFFFFF - $urandom_range(3);
      3: return $signed($urandom_range(131072)) - 65536;
      default: return $signed($urandom_range(1048576)) - 524288;
    endcase
  endfunction

  task automatic send_matrix(logic [31:0] m [9]);
    while ($urandom_range(99) < send_idle) begin
      din.valid <= 0;
      @(negedge clk);
    end
    din.valid <= 1;
    {din.in_c0_r0, din.in_c0_r1, din.in_c0_r2, din.in_c1_r0, din.in_c1_r1, din.in_c1_r2,
     din.in_c2_r0, din.in_c2_r1, din.in_c2_r2} <= {m[0], m[1], m[2], m[3], m[4], m[5],
                                                  m[6], m[7], m[8]};
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    din.valid <= 0;
    while (pending > 0) @(negedge clk);
    repeat (50) @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_random(int count);
    logic [31:0] m [9];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      if (kind == 0) begin
        for (int i = 0; i < 3; i++) m[6 + i] = m[i];
      end else if (kind < 4) begin
        for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? rand_elem() : 32'h0;
      end
      send_matrix(m);
    end
  endtask

  initial begin
    logic [31:0] m [9];
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    din.valid = 0;
    {din.in_c0_r0, din.in_c0_r1, din.in_c0_r2, din.in_c1_r0, din.in_c1_r1, din.in_c1_r2,
     din.in_c2_r0, din.in_c2_r1, din.in_c2_r2} = '0;
    send_idle = 0; sink_stall = 0; hold_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_matrix(m);
    m = '{default: 32'h0};
    send_matrix(m);
    m = '{default: 32'h7FFFFFFF};
    send_matrix(m);
    m = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
    send_matrix(m);
    m = '{32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100};
    send_matrix(m);
    m = '{32'h20000, 32'h10000, 0, 32'h10000, 32'h20000, 32'h10000, 0, 32'h10000,
          32'h20000};
    send_matrix(m);
    m = '{32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h12345678, 32'hEDCBA987, 3,
          32'h55555555, 32'hAAAAAAAA, 32'hFFFF0000};
    send_matrix(m);

    write_threshold(0);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{default: 32'h0};
    send_matrix(m);
    send_random(200);

    write_threshold(32'h7FFFFFFF);
    send_random(100);

    write_threshold(32'h00000004);
    send_random(300);

    send_idle = 46;
    send_random(300);
    send_idle = 0; sink_stall = 46;
    send_random(300);
    send_idle = 17; sink_stall = 17;
    send_random(300);
    send_idle = 0; sink_stall = 0;
    hold_cycles = 300;
    send_random(150);

    din.valid <= 0;
    while (pending > 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
